/* src/pdrc_pkg.sv */
// pdrc_pkg: shared codes, tables and DM-RS position functions for the
// PDSCH DM-RS resource-element classifier. No dependencies.
package pdrc_pkg;

  localparam int unsigned NumSymbols = 14;
  localparam int unsigned NumSubcarriers = 12;

  // configuration register indexes
  localparam logic [2:0] REG_MAPPING_TYPE     = 3'd0;
  localparam logic [2:0] REG_START_SYMBOL     = 3'd1;
  localparam logic [2:0] REG_ALLOC_LENGTH     = 3'd2;
  localparam logic [2:0] REG_DMRS_CONFIG_TYPE = 3'd3;
  localparam logic [2:0] REG_DOUBLE_SYMBOL    = 3'd4;
  localparam logic [2:0] REG_TYPEA_POSITION   = 3'd5;
  localparam logic [2:0] REG_ADDITIONAL_POS   = 3'd6;
  localparam logic [2:0] REG_PORT_OFFSET      = 3'd7;

  // resource element classes
  localparam logic [1:0] CLS_OUTSIDE = 2'd0;
  localparam logic [1:0] CLS_DATA    = 2'd1;
  localparam logic [1:0] CLS_DMRS    = 2'd2;

  typedef logic [NumSymbols-1:0] sym_mask_t;

  // per-port subcarrier offsets
  localparam logic [2:0] DELTA_TYPE1 [8] = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd0, 3'd1, 3'd1};
  localparam logic [2:0] DELTA_TYPE2 [12] = '{3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd4,
                                              3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd4};

  localparam logic [11:0] COMB_TYPE1 = 12'h555;
  localparam logic [11:0] COMB_TYPE2 = 12'h0C3;

  function automatic sym_mask_t sym_bit(input logic [3:0] pos);
    sym_mask_t m;
    m = '0;
    m[pos] = 1'b1;
    return m;
  endfunction

  // base positions, single-symbol DM-RS
  function automatic sym_mask_t single_positions(input logic type_b, input logic [1:0] l0,
                                                 input logic [4:0] ld, input logic [1:0] apos);
    sym_mask_t b;
    sym_mask_t r;
    b = sym_bit({2'b00, l0});
    r = '0;
    if (!type_b) begin
      if (ld == 5'd3) begin
        r = (l0 == 2'd2) ? b : '0;
      end else if (ld >= 5'd4 && ld <= 5'd7) begin
        r = b;
      end else if (ld == 5'd8 || ld == 5'd9) begin
        r = (apos == 2'd0) ? b : (b | sym_bit(4'd7));
      end else if (ld == 5'd10 || ld == 5'd11) begin
        case (apos)
          2'd0:    r = b;
          2'd1:    r = b | sym_bit(4'd9);
          default: r = b | sym_bit(4'd6) | sym_bit(4'd9);
        endcase
      end else if (ld == 5'd12) begin
        case (apos)
          2'd0:    r = b;
          2'd1:    r = b | sym_bit(4'd9);
          2'd2:    r = b | sym_bit(4'd6) | sym_bit(4'd9);
          default: r = b | sym_bit(4'd5) | sym_bit(4'd8) | sym_bit(4'd11);
        endcase
      end else if (ld == 5'd13 || ld == 5'd14) begin
        case (apos)
          2'd0:    r = b;
          2'd1:    r = b | sym_bit(4'd11);
          2'd2:    r = b | sym_bit(4'd7) | sym_bit(4'd11);
          default: r = b | sym_bit(4'd5) | sym_bit(4'd8) | sym_bit(4'd11);
        endcase
      end
    end else begin
      if (ld == 5'd2 || ld == 5'd4) begin
        r = (apos <= 2'd1) ? b : '0;
      end else if (ld == 5'd6 || ld == 5'd7) begin
        case (apos)
          2'd0:    r = b;
          2'd1:    r = b | sym_bit(4'd4);
          default: r = '0;
        endcase
      end
    end
    return r;
  endfunction

  // base positions, double-symbol DM-RS (first symbol of each pair)
  function automatic sym_mask_t double_positions(input logic type_b, input logic [1:0] l0,
                                                 input logic [4:0] ld, input logic [1:0] apos);
    sym_mask_t b;
    sym_mask_t r;
    b = sym_bit({2'b00, l0});
    r = '0;
    if (!type_b) begin
      if (ld == 5'd4) begin
        r = (l0 == 2'd2 && apos <= 2'd1) ? b : '0;
      end else if (ld >= 5'd5 && ld <= 5'd9) begin
        r = (apos <= 2'd1) ? b : '0;
      end else if (ld >= 5'd10 && ld <= 5'd12) begin
        case (apos)
          2'd0:    r = b;
          2'd1:    r = b | sym_bit(4'd8);
          default: r = '0;
        endcase
      end else if (ld == 5'd13 || ld == 5'd14) begin
        case (apos)
          2'd0:    r = b;
          2'd1:    r = b | sym_bit(4'd10);
          default: r = '0;
        endcase
      end
    end else begin
      if (ld == 5'd6 || ld == 5'd7) begin
        r = (apos <= 2'd1) ? b : '0;
      end
    end
    return r;
  endfunction

endpackage

/* src/pdsch_dmrs_re_classifier_top.sv */
// PDSCH DM-RS resource-element classifier: one element accepted every cycle;
// busy is never raised.
// Input register, classification logic, result register; done marks each result
// for one cycle and the receiver cannot stall.
// Synchronous active-high rst clears the pipeline valids and loads register defaults.
// Depends on pdrc_pkg.
module pdsch_dmrs_re_classifier_top
  import pdrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] symbol_index,
  input  logic [3:0] subcarrier,
  output logic       done,
  output logic [1:0] re_class,
  output logic       port_invalid,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [3:0] cfg_data
);

  logic       mapping_type;
  logic [3:0] start_symbol;
  logic [3:0] alloc_length;
  logic       dmrs_config_type;
  logic       double_symbol;
  logic [1:0] typea_position;
  logic [1:0] additional_position;
  logic [3:0] port_offset;

  logic       in_valid;
  logic [3:0] in_sym;
  logic [3:0] in_sc;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapping_type        <= 1'b0;
      start_symbol        <= 4'd0;
      alloc_length        <= 4'd14;
      dmrs_config_type    <= 1'b0;
      double_symbol       <= 1'b0;
      typea_position      <= 2'd2;
      additional_position <= 2'd2;
      port_offset         <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAPPING_TYPE:     mapping_type        <= cfg_data[0];
        REG_START_SYMBOL:     start_symbol        <= cfg_data;
        REG_ALLOC_LENGTH:     alloc_length        <= cfg_data;
        REG_DMRS_CONFIG_TYPE: dmrs_config_type    <= cfg_data[0];
        REG_DOUBLE_SYMBOL:    double_symbol       <= cfg_data[0];
        REG_TYPEA_POSITION:   typea_position      <= cfg_data[1:0];
        REG_ADDITIONAL_POS:   additional_position <= cfg_data[1:0];
        REG_PORT_OFFSET:      port_offset         <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_sym <= symbol_index;
      in_sc  <= subcarrier;
    end
  end

  // classification
  logic [1:0]  l0;
  logic [4:0]  ld;
  logic [4:0]  alloc_end;
  sym_mask_t   base_single;
  sym_mask_t   base_double;
  sym_mask_t   base;
  sym_mask_t   symbols;
  logic        invalid;
  logic [2:0]  delta;
  logic [15:0] scmask;
  logic        in_alloc;
  logic [1:0]  cls;

  always_comb begin
    l0 = mapping_type ? 2'd0 : typea_position;
    ld = mapping_type ? {1'b0, alloc_length} : ({1'b0, start_symbol} + {1'b0, alloc_length});
    base_single = single_positions(mapping_type, l0, ld, additional_position);
    base_double = double_positions(mapping_type, l0, ld, additional_position);
    // pairs run past symbol 13 are dropped by the mask width
    base = double_symbol ? (base_double | (base_double << 1)) : base_single;
    symbols = mapping_type ? sym_mask_t'(base << start_symbol) : base;

    if (!dmrs_config_type) begin
      invalid = (port_offset > 4'd7);
      delta   = invalid ? 3'd0 : DELTA_TYPE1[port_offset[2:0]];
      scmask  = {4'b0000, 12'(COMB_TYPE1 << delta)};
    end else begin
      invalid = (port_offset > 4'd11);
      delta   = invalid ? 3'd0 : DELTA_TYPE2[port_offset];
      scmask  = {4'b0000, 12'(COMB_TYPE2 << delta)};
    end

    alloc_end = {1'b0, start_symbol} + {1'b0, alloc_length};
    in_alloc  = (in_sym <= 4'd13) && (in_sym >= start_symbol) && ({1'b0, in_sym} < alloc_end);

    if (!in_alloc) begin
      cls = CLS_OUTSIDE;
    end else if (symbols[in_sym] && scmask[in_sc]) begin
      cls = CLS_DMRS;
    end else begin
      cls = CLS_DATA;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      re_class     <= cls;
      port_invalid <= invalid;
    end
  end

endmodule

/* test/pdsch_dmrs_re_classifier_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pdsch_dmrs_re_classifier_top: directed corner elements,
// then randomised register settings and element streams, checked against an
// in-bench classifier. Depends on pdrc_pkg and the classifier top level.
module pdsch_dmrs_re_classifier_top_tb;
  import pdrc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomElements = 750;

  typedef struct {
    logic [1:0] cls;
    logic       inv;
  } re_verdict_t;

  typedef struct {
    logic       map_b;
    logic [3:0] start_sym;
    logic [3:0] alloc_len;
    logic       cfg_type2;
    logic       dbl;
    logic [1:0] l0_a;
    logic [1:0] apos;
    logic [3:0] port;
  } slot_cfg_t;

  class re_class_scoreboard;
    re_verdict_t verdict_q[$];
    int unsigned errors;
    int unsigned accepted;
    int unsigned checked;
    slot_cfg_t   regs;

    function new();
      regs.map_b = 1'b0;
      regs.start_sym = 4'd0;
      regs.alloc_len = 4'd14;
      regs.cfg_type2 = 1'b0;
      regs.dbl = 1'b0;
      regs.l0_a = 2'd2;
      regs.apos = 2'd2;
      regs.port = 4'd0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [3:0] data);
      case (idx)
        REG_MAPPING_TYPE:     regs.map_b = data[0];
        REG_START_SYMBOL:     regs.start_sym = data;
        REG_ALLOC_LENGTH:     regs.alloc_len = data;
        REG_DMRS_CONFIG_TYPE: regs.cfg_type2 = data[0];
        REG_DOUBLE_SYMBOL:    regs.dbl = data[0];
        REG_TYPEA_POSITION:   regs.l0_a = data[1:0];
        REG_ADDITIONAL_POS:   regs.apos = data[1:0];
        default:              regs.port = data;
      endcase
    endfunction

    // first symbol of every DM-RS occasion, one bit per symbol
    function int unsigned occasion_mask(bit map_b, bit dbl, int unsigned l0, int unsigned ld,
                                        int unsigned apos);
      int unsigned b;
      int unsigned m;
      b = 1 << l0;
      m = 0;
      if (!map_b && !dbl) begin
        case (ld)
          3:          m = (l0 == 2) ? b : 0;
          4, 5, 6, 7: m = b;
          8, 9:       m = (apos == 0) ? b : (b | (1 << 7));
          10, 11:     m = (apos == 0) ? b : (apos == 1) ? (b | (1 << 9)) :
                          (b | (1 << 6) | (1 << 9));
          12:         m = (apos == 0) ? b : (apos == 1) ? (b | (1 << 9)) :
                          (apos == 2) ? (b | (1 << 6) | (1 << 9)) :
                          (b | (1 << 5) | (1 << 8) | (1 << 11));
          13, 14:     m = (apos == 0) ? b : (apos == 1) ? (b | (1 << 11)) :
                          (apos == 2) ? (b | (1 << 7) | (1 << 11)) :
                          (b | (1 << 5) | (1 << 8) | (1 << 11));
          default:    m = 0;
        endcase
      end else if (map_b && !dbl) begin
        case (ld)
          2, 4:    m = (apos <= 1) ? b : 0;
          6, 7:    m = (apos == 0) ? b : (apos == 1) ? (b | (1 << 4)) : 0;
          default: m = 0;
        endcase
      end else if (!map_b) begin
        case (ld)
          4:             m = (l0 == 2 && apos <= 1) ? b : 0;
          5, 6, 7, 8, 9: m = (apos <= 1) ? b : 0;
          10, 11, 12:    m = (apos == 0) ? b : (apos == 1) ? (b | (1 << 8)) : 0;
          13, 14:        m = (apos == 0) ? b : (apos == 1) ? (b | (1 << 10)) : 0;
          default:       m = 0;
        endcase
      end else begin
        m = ((ld == 6 || ld == 7) && apos <= 1) ? b : 0;
      end
      return m;
    endfunction

    function void note_element(logic [3:0] sym, logic [3:0] sc);
      int unsigned l0;
      int unsigned ld;
      int unsigned syms;
      int unsigned delta;
      int unsigned comb;
      int unsigned first;
      int unsigned stop;
      re_verdict_t v;
      l0 = regs.map_b ? 0 : regs.l0_a;
      first = regs.start_sym;
      stop = first + regs.alloc_len;
      ld = regs.map_b ? regs.alloc_len : stop;
      syms = occasion_mask(regs.map_b, regs.dbl, l0, ld, regs.apos);
      if (regs.dbl) syms = syms | (syms << 1);
      if (regs.map_b) syms = syms << first;
      syms = syms & 32'h3fff;
      // delta follows the CDM group: type 1 alternates by port pairs, type 2 steps through 0/2/4 by port pairs
      if (!regs.cfg_type2) begin
        v.inv = (regs.port > 7);
        delta = v.inv ? 0 : regs.port[1];
        comb = (32'h555 << delta) & 32'hfff;
      end else begin
        v.inv = (regs.port > 11);
        delta = v.inv ? 0 : 2 * ((regs.port >> 1) % 3);
        comb = (32'h0c3 << delta) & 32'hfff;
      end
      if (sym > 13 || sym < first || sym >= stop) v.cls = CLS_OUTSIDE;
      else if (syms[sym] && sc < 12 && comb[sc]) v.cls = CLS_DMRS;
      else v.cls = CLS_DATA;
      verdict_q.push_back(v);
      accepted++;
    endfunction

    function void mismatch(string what, int unsigned exp_v, int unsigned act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
    endfunction

    function void check_result(logic [1:0] cls, logic inv);
      re_verdict_t v;
      if (verdict_q.size() == 0) begin
        mismatch("unexpected result, re_class", 4, cls);
        return;
      end
      v = verdict_q.pop_front();
      checked++;
      if (cls !== v.cls) mismatch("re_class", v.cls, cls);
      if (inv !== v.inv) mismatch("port_invalid", v.inv, inv);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [3:0] symbol_index = '0;
  logic [3:0] subcarrier = '0;
  logic       done;
  logic [1:0] re_class;
  logic       port_invalid;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  re_class_scoreboard sb = new();
  bit          gaps_on = 1'b1;
  int unsigned cycles = 0;
  int unsigned settings_loaded = 0;

  pdsch_dmrs_re_classifier_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .symbol_index(symbol_index), .subcarrier(subcarrier),
    .done(done), .re_class(re_class), .port_invalid(port_invalid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_element(symbol_index, subcarrier);
      if (done) sb.check_result(re_class, port_invalid);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic slot_cfg_t make_cfg(logic mb, logic [3:0] s, logic [3:0] l, logic t2,
                                         logic d, logic [1:0] l0, logic [1:0] ap,
                                         logic [3:0] p);
    slot_cfg_t c;
    c.map_b = mb;
    c.start_sym = s;
    c.alloc_len = l;
    c.cfg_type2 = t2;
    c.dbl = d;
    c.l0_a = l0;
    c.apos = ap;
    c.port = p;
    return c;
  endfunction

  function automatic slot_cfg_t rand_cfg();
    slot_cfg_t c;
    c.cfg_type2 = 1'($urandom_range(0, 1));
    c.dbl = 1'($urandom_range(0, 1));
    c.apos = 2'($urandom_range(0, 3));
    c.l0_a = 2'($urandom_range(2, 3));
    c.port = c.cfg_type2 ? 4'($urandom_range(0, 11)) : 4'($urandom_range(0, 7));
    c.map_b = 1'($urandom_range(0, 1));
    if (!c.map_b) begin
      c.start_sym = 4'($urandom_range(0, 3));
      c.alloc_len = 4'($urandom_range(3, 14 - c.start_sym));
    end else begin
      c.start_sym = 4'($urandom_range(0, 12));
      case ($urandom_range(0, 4))
        0:       c.alloc_len = 4'd2;
        1:       c.alloc_len = 4'd4;
        2:       c.alloc_len = 4'd6;
        3:       c.alloc_len = 4'd7;
        default: c.alloc_len = 4'($urandom_range(2, 14));
      endcase
    end
    // noise settings over the full register widths
    if ($urandom_range(0, 4) == 0) begin
      c = make_cfg(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    end else if ($urandom_range(0, 9) == 0) begin
      c.port = 4'($urandom_range(0, 15));
    end
    return c;
  endfunction

  // writes all eight registers, valid held high across beats
  task automatic load_config(input slot_cfg_t c);
    logic [3:0] val [8];
    val[REG_MAPPING_TYPE] = {3'b000, c.map_b};
    val[REG_START_SYMBOL] = c.start_sym;
    val[REG_ALLOC_LENGTH] = c.alloc_len;
    val[REG_DMRS_CONFIG_TYPE] = {3'b000, c.cfg_type2};
    val[REG_DOUBLE_SYMBOL] = {3'b000, c.dbl};
    val[REG_TYPEA_POSITION] = {2'b00, c.l0_a};
    val[REG_ADDITIONAL_POS] = {2'b00, c.apos};
    val[REG_PORT_OFFSET] = c.port;
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_element(input logic [3:0] sym, input logic [3:0] sc);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    symbol_index <= sym;
    subcarrier <= sc;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    start <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random();
    logic [3:0] sym;
    logic [3:0] sc;
    sym = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(14, 15)) : 4'($urandom_range(0, 13));
    sc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
    send_element(sym, sc);
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned phase;
    sent = 0;
    phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults straight after reset
    send_element(4'd2, 4'd0);
    send_element(4'd14, 4'd0);
    send_element(4'd2, 4'd12);
    send_element(4'd0, 4'd15);
    settle();
    // type A, type 2 comb, double symbol from l0 3, highest valid port
    load_config(make_cfg(1'b0, 4'd0, 4'd14, 1'b1, 1'b1, 2'd3, 2'd1, 4'd11));
    send_element(4'd3, 4'd4);
    send_element(4'd4, 4'd5);
    send_element(4'd11, 4'd4);
    settle();
    // type B running past the slot end with a port beyond the table
    load_config(make_cfg(1'b1, 4'd12, 4'd14, 1'b0, 1'b0, 2'd2, 2'd0, 4'd15));
    send_element(4'd12, 4'd0);
    send_element(4'd13, 4'd1);
    send_element(4'd11, 4'd5);
    settle();
    // type B with additional occasion, type 1 port just past the table
    load_config(make_cfg(1'b1, 4'd8, 4'd6, 1'b0, 1'b0, 2'd2, 2'd1, 4'd8));
    send_element(4'd8, 4'd0);
    send_element(4'd12, 4'd1);
    send_element(4'd13, 4'd15);
    settle();
    // empty allocation, l0 of zero
    load_config(make_cfg(1'b0, 4'd0, 4'd0, 1'b0, 1'b0, 2'd0, 2'd0, 4'd0));
    send_element(4'd0, 4'd0);
    settle();
    // l0 of one with three additional occasions
    load_config(make_cfg(1'b0, 4'd0, 4'd12, 1'b0, 1'b0, 2'd1, 2'd3, 4'd2));
    send_element(4'd1, 4'd1);
    send_element(4'd11, 4'd3);
    settle();
    // selector outside the double-symbol table
    load_config(make_cfg(1'b0, 4'd0, 4'd14, 1'b0, 1'b1, 2'd2, 2'd3, 4'd0));
    send_element(4'd2, 4'd0);
    settle();
    // every register at its top value
    load_config(make_cfg(1'b1, 4'd15, 4'd15, 1'b1, 1'b1, 2'd3, 2'd3, 4'd15));
    send_element(4'd15, 4'd15);
    send_element(4'd0, 4'd0);
    settle();

    while (sent < RandomElements) begin
      load_config(rand_cfg());
      gaps_on = ($urandom_range(0, 2) != 0);
      n = $urandom_range(25, 60);
      for (int unsigned i = 0; i < n; i++) begin
        if ((phase == 2 && i == n / 2) || $urandom_range(0, 199) == 0) settle();
        send_random();
        sent++;
      end
      settle();
      phase++;
    end

    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.errors += sb.verdict_q.size();
    $display("classified %0d elements under %0d register settings, %0d results compared",
             sb.accepted, settings_loaded, sb.checked);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/pdrc_pkg.sv
src/pdsch_dmrs_re_classifier_top.sv
test/pdsch_dmrs_re_classifier_top_tb.sv
